### rtl/ffba_pkg.sv
package ffba_pkg;

  localparam int CELLS = 128;
  localparam int IDX_W = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int CNT_W = $clog2(CELLS + 1);
  localparam int ID_W = 16;
  localparam int SIZE_W = 8;

  localparam logic [SIZE_W-1:0] MEM_SIZE_RESET = 8'd128;
  localparam logic [ID_W-1:0] ID_MAX = 16'hFFFF;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_ERASE = 2'd1;
  localparam logic [1:0] OP_DEFRAG = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  typedef struct packed {
    logic [1:0]        operation;
    logic [SIZE_W-1:0] request_size;
    logic [ID_W-1:0]   erase_id;
  } req_t;

  typedef struct packed {
    logic [1:0]      status;
    logic [ID_W-1:0] new_id;
  } rsp_t;

endpackage

### rtl/first_fit_block_allocator.sv
// First-fit block allocator over a row of CELLS owner cells kept in one RAM.
// Request channel (req_valid / req_stall / req): one operation per transfer,
// allocate, erase or defragment. Response channel (rsp_valid / rsp_stall /
// rsp): exactly one status and identifier per request, in request order.
// memory_size_we / memory_size_data write the in-use cell count; write it
// only while no request is outstanding.
// One request is worked on at a time; req_stall is high from acceptance until
// the response is loaded into the output register. The owner RAM streams one
// cell per cycle while scanning. What each operation does before its response:
//   allocate  : scan the in-use cells for the first free run that fits, then
//               write the new identifier into each granted cell
//   erase     : all cells are scanned
//   defragment: compact, then clear the tail
//   zero size, counter spent, id zero or an unused code: answered at once
// A new request is taken while the previous response still waits in the
// output register; if that register is still full when the next response is
// ready, the block waits until rsp_stall drops.
// Reset (rst, synchronous) marks every cell free through per-cell valid
// flags; the identifier counter returns to zero and memory_size to 128.
module first_fit_block_allocator (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_stall,
  input  ffba_pkg::req_t                  req,
  output logic                            rsp_valid,
  input  logic                            rsp_stall,
  output ffba_pkg::rsp_t                  rsp,
  input  logic                            memory_size_we,
  input  logic [ffba_pkg::SIZE_W-1:0]     memory_size_data
);

  import ffba_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC_SCAN,
    S_ALLOC_FILL,
    S_ERASE_SCAN,
    S_DEFRAG_SCAN,
    S_DEFRAG_CLEAR,
    S_DONE
  } state_t;

  state_t            state;
  logic [SIZE_W-1:0] memory_size;
  logic [CELLS-1:0]  cell_valid;
  logic [ID_W-1:0]   next_id;

  logic [CNT_W-1:0]  scan;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;
  logic              rd_vbit;

  logic [CNT_W-1:0]  run;
  logic [IDX_W-1:0]  run_start;
  logic [IDX_W-1:0]  fill;
  logic [IDX_W-1:0]  fill_end;
  logic [CNT_W-1:0]  dst;
  logic              live;
  logic [SIZE_W-1:0] want;
  logic [ID_W-1:0]   erase_key;
  rsp_t              res;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  scan_lim;
  logic              scanning;
  logic              issue;
  logic [IDX_W-1:0]  raddr;
  logic [ID_W-1:0]   rdata;
  logic [ID_W-1:0]   cur_owner;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [ID_W-1:0]   wdata;
  logic              alloc_hit;

  ffba_ram #(
    .WIDTH(ID_W),
    .DEPTH(CELLS)
  ) u_owner_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    if (32'(memory_size) > CELLS) begin
      lim = CNT_W'(CELLS);
    end else begin
      lim = CNT_W'(memory_size);
    end
  end

  assign scan_lim = (state == S_ERASE_SCAN) ? CNT_W'(CELLS) : lim;
  assign scanning = (state == S_ALLOC_SCAN) || (state == S_ERASE_SCAN) ||
                    (state == S_DEFRAG_SCAN);
  assign issue    = scanning && (scan < scan_lim);
  assign raddr    = scan[IDX_W-1:0];

  // never-written cells read as free
  assign cur_owner = rd_vbit ? rdata : '0;

  assign alloc_hit = rd_pend && (cur_owner == '0) && ((32'(run) + 1) == 32'(want));

  always_comb begin
    we    = 1'b0;
    waddr = rd_idx;
    wdata = '0;
    case (state)
      S_ALLOC_FILL: begin
        we    = 1'b1;
        waddr = fill;
        wdata = next_id + 1'b1;
      end
      S_ERASE_SCAN: begin
        if (rd_pend && (cur_owner == erase_key)) begin
          we = 1'b1;
        end
      end
      S_DEFRAG_SCAN: begin
        // destination never passes the cell being read, so no hazard
        if (rd_pend && (cur_owner != '0)) begin
          we    = 1'b1;
          waddr = dst[IDX_W-1:0];
          wdata = cur_owner;
        end
      end
      S_DEFRAG_CLEAR: begin
        if (dst < lim) begin
          we    = 1'b1;
          waddr = dst[IDX_W-1:0];
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      memory_size <= MEM_SIZE_RESET;
      cell_valid  <= '0;
      next_id     <= '0;
      rd_pend     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      if (memory_size_we) begin
        memory_size <= memory_size_data;
      end
      // S_DONE reloads the output register itself
      if (rsp_valid && !rsp_stall && (state != S_DONE)) begin
        rsp_valid <= 1'b0;
      end
      if (we) begin
        cell_valid[waddr] <= 1'b1;
      end

      rd_pend <= issue;
      if (issue) begin
        rd_idx  <= raddr;
        rd_vbit <= cell_valid[raddr];
        scan    <= scan + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (req_valid) begin
            want       <= req.request_size;
            erase_key  <= req.erase_id;
            scan       <= '0;
            run        <= '0;
            dst        <= '0;
            live       <= 1'b0;
            res.new_id <= '0;
            case (req.operation)
              OP_ALLOC: begin
                if ((req.request_size == '0) || (next_id == ID_MAX)) begin
                  res.status <= ST_NOSPACE;
                  state      <= S_DONE;
                end else begin
                  res.status <= ST_OK;
                  state      <= S_ALLOC_SCAN;
                end
              end
              OP_ERASE: begin
                if (req.erase_id == '0) begin
                  res.status <= ST_ILLEGAL;
                  state      <= S_DONE;
                end else begin
                  res.status <= ST_OK;
                  state      <= S_ERASE_SCAN;
                end
              end
              OP_DEFRAG: begin
                res.status <= ST_OK;
                state      <= S_DEFRAG_SCAN;
              end
              default: begin
                res.status <= ST_OK;
                state      <= S_DONE;
              end
            endcase
          end
        end

        S_ALLOC_SCAN: begin
          if (rd_pend) begin
            if (cur_owner == '0) begin
              run <= run + 1'b1;
              if (run == '0) begin
                run_start <= rd_idx;
              end
            end else begin
              run <= '0;
            end
          end
          if (alloc_hit) begin
            // drop the read still in flight and fill the run
            fill     <= (run == '0) ? rd_idx : run_start;
            fill_end <= rd_idx;
            state    <= S_ALLOC_FILL;
          end else if (!rd_pend && !issue) begin
            res.status <= ST_NOSPACE;
            state      <= S_DONE;
          end
        end

        S_ALLOC_FILL: begin
          fill <= fill + 1'b1;
          if (fill == fill_end) begin
            next_id    <= next_id + 1'b1;
            res.new_id <= next_id + 1'b1;
            state      <= S_DONE;
          end
        end

        S_ERASE_SCAN: begin
          if (we) begin
            live <= 1'b1;
          end
          if (!rd_pend && !issue) begin
            res.status <= live ? ST_OK : ST_ILLEGAL;
            state      <= S_DONE;
          end
        end

        S_DEFRAG_SCAN: begin
          if (we) begin
            dst <= dst + 1'b1;
          end
          if (!rd_pend && !issue) begin
            state <= S_DEFRAG_CLEAR;
          end
        end

        S_DEFRAG_CLEAR: begin
          if (dst < lim) begin
            dst <= dst + 1'b1;
          end else begin
            state <= S_DONE;
          end
        end

        S_DONE: begin
          // hold until the output register is free
          if (!rsp_valid || !rsp_stall) begin
            rsp       <= res;
            rsp_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/ffba_ram.sv
module ffba_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffba_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SIM_LIMIT = 1_500_000;
  localparam int IDLE_PCT = 17;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic memory_size_we = 1'b0;
  logic [SIZE_W-1:0] memory_size_data = '0;

  // shadow of the allocator state
  logic [ID_W-1:0] owner_of [CELLS] = '{default: '0};
  logic [ID_W-1:0] last_id = '0;
  logic [SIZE_W-1:0] region_size = MEM_SIZE_RESET;

  req_t req_queue[$];
  rsp_t expected_rsp[$];
  rsp_t want;

  logic idle_on = 1'b1;
  int cycle_count = 0;
  int error_count = 0;
  int req_count = 0;
  int rsp_count = 0;
  int grants = 0;
  int no_space_count = 0;
  int erase_count = 0;
  int reject_count = 0;
  int defrag_count = 0;
  int region_writes = 0;

  first_fit_block_allocator u_dut (
    .clk              (clk),
    .rst              (rst),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .req              (req),
    .rsp_valid        (rsp_valid),
    .rsp_stall        (rsp_stall),
    .rsp              (rsp),
    .memory_size_we   (memory_size_we),
    .memory_size_data (memory_size_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  task automatic report_error(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // Apply one request to the shadow state and return the response it yields.
  function automatic rsp_t predict_allocator(input req_t r);
    rsp_t res;
    int lim;
    int run;
    int dst;
    int k;
    logic hit;
    res = '0;
    lim = (int'(region_size) > CELLS) ? CELLS : int'(region_size);
    case (r.operation)
      OP_ALLOC: begin
        res.status = ST_NOSPACE;
        run = 0;
        if (r.request_size != '0 && last_id != ID_MAX) begin
          for (k = 0; k < lim; k++) begin
            if (owner_of[k] != '0) begin
              run = 0;
            end else begin
              run++;
              if (run == int'(r.request_size)) begin
                last_id = last_id + 1'b1;
                for (dst = k + 1 - run; dst <= k; dst++) owner_of[dst] = last_id;
                res.status = ST_OK;
                res.new_id = last_id;
                break;
              end
            end
          end
        end
        if (res.status == ST_OK) grants++;
        else no_space_count++;
      end
      OP_ERASE: begin
        // liveness looks at every cell, not just the region in use
        hit = 1'b0;
        for (k = 0; k < CELLS; k++)
          if (r.erase_id != '0 && owner_of[k] == r.erase_id) hit = 1'b1;
        if (hit) begin
          for (k = 0; k < CELLS; k++)
            if (owner_of[k] == r.erase_id) owner_of[k] = '0;
          erase_count++;
        end else begin
          res.status = ST_ILLEGAL;
          reject_count++;
        end
      end
      OP_DEFRAG: begin
        dst = 0;
        for (k = 0; k < lim; k++) begin
          if (owner_of[k] != '0) begin
            owner_of[dst] = owner_of[k];
            dst++;
          end
        end
        for (k = dst; k < lim; k++) owner_of[k] = '0;
        defrag_count++;
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input logic [1:0] op, input int size, input int id);
    req_t r;
    r.operation = op;
    r.request_size = SIZE_W'(size);
    r.erase_id = ID_W'(id);
    return r;
  endfunction

  // Mostly allocations of small blocks and erases of live blocks; some noise.
  function automatic req_t random_request();
    req_t r;
    int pick;
    int c;
    int k;
    r.operation = OP_ALLOC;
    r.request_size = SIZE_W'($urandom);
    r.erase_id = ID_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 48) begin
      c = $urandom_range(99);
      if (c < 70) r.request_size = SIZE_W'($urandom_range(16, 1));
      else if (c < 88) r.request_size = SIZE_W'($urandom_range(64, 1));
      else if (c < 94) r.request_size = SIZE_W'($urandom_range(128, 65));
      else if (c < 97) r.request_size = '0;
      else r.request_size = SIZE_W'($urandom_range(255, 129));
    end else if (pick < 83) begin
      r.operation = OP_ERASE;
      c = $urandom_range(99);
      if (c < 78) begin
        // take the owner of some occupied cell
        pick = $urandom_range(CELLS - 1);
        for (k = 0; k < CELLS; k++) begin
          if (owner_of[(pick + k) % CELLS] != '0) begin
            r.erase_id = owner_of[(pick + k) % CELLS];
            break;
          end
        end
      end else if (c < 84) begin
        r.erase_id = '0;
      end else if (c < 90) begin
        r.erase_id = last_id + 1'b1;
      end else if (c < 94) begin
        r.erase_id = last_id;
      end
    end else if (pick < 96) begin
      r.operation = OP_DEFRAG;
    end else begin
      r.operation = OP_UNUSED;
    end
    return r;
  endfunction

  // Request driver: hold the payload until the transfer, idle at random.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || !req_stall) begin
      if (req_queue.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
        req_valid <= 1'b1;
        req <= req_queue.pop_front();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) rsp_stall <= 1'b0;
    else rsp_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
  end

  // Monitor: check response transfers, then predict for request transfers.
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        rsp_count++;
        if (expected_rsp.size() == 0) begin
          report_error($sformatf("response %0h/%0h with nothing outstanding",
                                 rsp.status, rsp.new_id));
        end else begin
          want = expected_rsp.pop_front();
          if (rsp.status !== want.status)
            report_error($sformatf("response %0d: status %0h, expected %0h",
                                   rsp_count, rsp.status, want.status));
          if (rsp.new_id !== want.new_id)
            report_error($sformatf("response %0d: new_id %0h, expected %0h",
                                   rsp_count, rsp.new_id, want.new_id));
        end
      end
      if (req_valid && !req_stall) begin
        req_count++;
        expected_rsp.push_back(predict_allocator(req));
      end
    end
  end

  task automatic wait_drained();
    while (req_queue.size() != 0 || req_valid || expected_rsp.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_region(input int value);
    wait_drained();
    @(posedge clk);
    memory_size_we <= 1'b1;
    memory_size_data <= SIZE_W'(value);
    @(posedge clk);
    memory_size_we <= 1'b0;
    region_size = SIZE_W'(value);
    region_writes++;
  endtask

  task automatic run_random(input int n);
    int i;
    for (i = 0; i < n; i++) begin
      while (req_queue.size() >= 2) @(negedge clk);
      // hold the sender once per phase until every response is back
      if (i == n / 2) wait_drained();
      req_queue.push_back(random_request());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    req_queue.push_back(make_req(OP_ALLOC, 0, 0));
    req_queue.push_back(make_req(OP_ERASE, 0, 0));
    req_queue.push_back(make_req(OP_ERASE, 255, 16'hFFFF));
    req_queue.push_back(make_req(OP_UNUSED, 255, 16'hFFFF));
    req_queue.push_back(make_req(OP_DEFRAG, 0, 0));
    req_queue.push_back(make_req(OP_ALLOC, 128, 0));
    req_queue.push_back(make_req(OP_ALLOC, 1, 0));
    req_queue.push_back(make_req(OP_DEFRAG, 0, 0));
    req_queue.push_back(make_req(OP_ERASE, 0, 1));
    req_queue.push_back(make_req(OP_ALLOC, 129, 0));
    req_queue.push_back(make_req(OP_ALLOC, 255, 0));
    req_queue.push_back(make_req(OP_ALLOC, 10, 0));
    req_queue.push_back(make_req(OP_ALLOC, 20, 0));
    req_queue.push_back(make_req(OP_ALLOC, 5, 0));
    req_queue.push_back(make_req(OP_ERASE, 0, 3));
    req_queue.push_back(make_req(OP_ALLOC, 25, 0));
    req_queue.push_back(make_req(OP_ALLOC, 15, 0));
    req_queue.push_back(make_req(OP_ERASE, 0, 2));
    req_queue.push_back(make_req(OP_DEFRAG, 0, 0));
    req_queue.push_back(make_req(OP_ERASE, 0, 6));
    req_queue.push_back(make_req(OP_ALLOC, 16, 0));
    req_queue.push_back(make_req(OP_ALLOC, 15, 0));
    req_queue.push_back(make_req(OP_ALLOC, 83, 0));
    req_queue.push_back(make_req(OP_UNUSED, 0, 0));

    set_region(255);
    run_random(200);
    set_region(0);
    run_random(60);
    set_region(1);
    run_random(60);
    set_region(37);
    run_random(180);
    set_region(128);
    // keep both sides busy through this whole phase
    idle_on = 1'b0;
    run_random(220);
    wait_drained();
    idle_on = 1'b1;
    // shrink the region while blocks still sit above it
    set_region(20);
    run_random(140);
    set_region(128);
    run_random(200);

    wait_drained();
    repeat (2 * CELLS + 16) @(negedge clk);
    $display("Checked %0d responses for %0d requests across %0d region settings.",
             rsp_count, req_count, region_writes);
    $display("Grants %0d, no-space %0d, erases %0d, rejected erases %0d, compactions %0d.",
             grants, no_space_count, erase_count, reject_count, defrag_count);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    wait (cycle_count >= SIM_LIMIT);
    $display("ERROR: timeout after %0d cycles, %0d responses outstanding",
             cycle_count, expected_rsp.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/ffba_pkg.sv
rtl/ffba_ram.sv
rtl/first_fit_block_allocator.sv
sim/tb.sv
